[hw/rtl/pdc_pkg.sv]
// Shared types, constants and helpers for the Playfair digram cipher.
// No dependencies; used by pdc_prio_enc and playfair_digram_cipher_top.
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int unsigned Side = 5;
  localparam int unsigned Cells = Side * Side;
  localparam int unsigned LetterW = 5;
  localparam int unsigned RowW = Side * LetterW;
  localparam int unsigned IdxW = 3;

  localparam logic [LetterW-1:0] LetterJ = 5'd9;
  localparam logic [LetterW-1:0] LetterI = 5'd8;

  // reset key square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
  localparam logic [RowW-1:0] SquareRow0Rst = 25'd4294688;
  localparam logic [RowW-1:0] SquareRow1Rst = 25'd10755269;
  localparam logic [RowW-1:0] SquareRow2Rst = 25'd16201099;
  localparam logic [RowW-1:0] SquareRow3Rst = 25'd21613104;
  localparam logic [RowW-1:0] SquareRow4Rst = 25'd27025109;

  typedef enum logic [2:0] {
    REG_DECRYPT_MODE = 3'd0,
    REG_SQUARE_ROW0  = 3'd1,
    REG_SQUARE_ROW1  = 3'd2,
    REG_SQUARE_ROW2  = 3'd3,
    REG_SQUARE_ROW3  = 3'd4,
    REG_SQUARE_ROW4  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LetterW-1:0] first_letter;
    logic [LetterW-1:0] second_letter;
  } in_beat_t;

  typedef struct packed {
    logic [LetterW-1:0] first_result;
    logic [LetterW-1:0] second_result;
    logic               not_in_square;
  } out_beat_t;

  // square position of a letter
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } loc_t;

  // row or column index stepped by one, modulo the side
  function automatic logic [IdxW-1:0] step_idx(input logic [IdxW-1:0] idx,
                                              input logic dec);
    logic [IdxW-1:0] res;
    if (dec) begin
      res = (idx == '0) ? IdxW'(Side - 1) : idx - 1'b1;
    end else begin
      res = (idx == IdxW'(Side - 1)) ? '0 : idx + 1'b1;
    end
    return res;
  endfunction

  function automatic logic [LetterW-1:0] fold_j(input logic [LetterW-1:0] l);
    return (l == LetterJ) ? LetterI : l;
  endfunction

endpackage

[hw/rtl/pdc_prio_enc.sv]
// Priority encoder: first set cell of a row-major hit vector to row/column.
// Depends on pdc_pkg.
`timescale 1ns / 1ps

module pdc_prio_enc (
  input  logic [pdc_pkg::Cells-1:0] hit,
  output pdc_pkg::loc_t             loc
);

  always_comb begin
    loc = '0;
    // walk from the last cell down so the lowest matching cell wins
    for (int r = pdc_pkg::Side - 1; r >= 0; r--) begin
      for (int c = pdc_pkg::Side - 1; c >= 0; c--) begin
        if (hit[r * pdc_pkg::Side + c]) begin
          loc.found = 1'b1;
          loc.row   = pdc_pkg::IdxW'(r);
          loc.col   = pdc_pkg::IdxW'(c);
        end
      end
    end
  end

endmodule

[hw/rtl/playfair_digram_cipher_top.sv]
// Throughput: one digram per cycle while the output is not stalled by out_ready;
// five register stages (fold, cell compare, priority encode, shift/swap, square
// read-out) each hold one beat. Reset (rst, synchronous): pipeline emptied,
// decrypt_mode cleared, key square set to a..z without j in row-major order.
// Depends on pdc_pkg, pdc_prio_enc.
`timescale 1ns / 1ps

module playfair_digram_cipher_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [pdc_pkg::RowW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pdc_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pdc_pkg::out_beat_t          out_data
);

  localparam int unsigned LW = pdc_pkg::LetterW;
  localparam int unsigned IW = pdc_pkg::IdxW;

  // configuration
  logic                            decrypt_mode;
  logic [pdc_pkg::Side-1:0][pdc_pkg::RowW-1:0] square;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      square[0]    <= pdc_pkg::SquareRow0Rst;
      square[1]    <= pdc_pkg::SquareRow1Rst;
      square[2]    <= pdc_pkg::SquareRow2Rst;
      square[3]    <= pdc_pkg::SquareRow3Rst;
      square[4]    <= pdc_pkg::SquareRow4Rst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdc_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        pdc_pkg::REG_SQUARE_ROW0:  square[0]    <= cfg_data;
        pdc_pkg::REG_SQUARE_ROW1:  square[1]    <= cfg_data;
        pdc_pkg::REG_SQUARE_ROW2:  square[2]    <= cfg_data;
        pdc_pkg::REG_SQUARE_ROW3:  square[3]    <= cfg_data;
        pdc_pkg::REG_SQUARE_ROW4:  square[4]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its beat moves on
  logic va, vb, vc, vd;
  logic en_a, en_b, en_c, en_d, en_o;

  assign en_o     = !out_valid || out_ready;
  assign en_d     = !vd || en_o;
  assign en_c     = !vc || en_d;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) va        <= in_valid;
      if (en_b) vb        <= va;
      if (en_c) vc        <= vb;
      if (en_d) vd        <= vc;
      if (en_o) out_valid <= vd;
    end
  end

  // stage a: j folds to i
  logic [LW-1:0] a_l1, a_l2;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_l1 <= pdc_pkg::fold_j(in_data.first_letter);
      a_l2 <= pdc_pkg::fold_j(in_data.second_letter);
    end
  end

  // stage b: compare both letters against every cell
  logic [pdc_pkg::Cells-1:0] hit1, hit2, b_hit1, b_hit2;

  always_comb begin
    for (int r = 0; r < pdc_pkg::Side; r++) begin
      for (int c = 0; c < pdc_pkg::Side; c++) begin
        hit1[r * pdc_pkg::Side + c] = (square[r][c * LW +: LW] == a_l1);
        hit2[r * pdc_pkg::Side + c] = (square[r][c * LW +: LW] == a_l2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_hit1 <= hit1;
      b_hit2 <= hit2;
    end
  end

  // stage c: first hit in row-major order
  pdc_pkg::loc_t loc1, loc2, c_loc1, c_loc2;

  pdc_prio_enc u_enc1 (.hit(b_hit1), .loc(loc1));
  pdc_prio_enc u_enc2 (.hit(b_hit2), .loc(loc2));

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_loc1 <= loc1;
      c_loc2 <= loc2;
    end
  end

  // stage d: digram rules give the two output cells
  logic [IW-1:0] o1r, o1c, o2r, o2c;
  logic [IW-1:0] d_o1r, d_o1c, d_o2r, d_o2c;
  logic          miss, d_miss;
  logic          same_row, same_col;

  assign miss     = !c_loc1.found || !c_loc2.found;
  assign same_row = (c_loc1.row == c_loc2.row);
  assign same_col = (c_loc1.col == c_loc2.col);

  always_comb begin
    o1r = c_loc1.row;
    o1c = c_loc2.col;
    o2r = c_loc2.row;
    o2c = c_loc1.col;
    if (same_row && same_col) begin
      o1r = pdc_pkg::step_idx(c_loc1.row, decrypt_mode);
      o1c = pdc_pkg::step_idx(c_loc1.col, decrypt_mode);
      o2r = o1r;
      o2c = o1c;
    end else if (same_row) begin
      o1c = pdc_pkg::step_idx(c_loc1.col, decrypt_mode);
      o2c = pdc_pkg::step_idx(c_loc2.col, decrypt_mode);
    end else if (same_col) begin
      o1r = pdc_pkg::step_idx(c_loc1.row, decrypt_mode);
      o2r = pdc_pkg::step_idx(c_loc2.row, decrypt_mode);
      o1c = c_loc1.col;
      o2c = c_loc2.col;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_o1r  <= o1r;
      d_o1c  <= o1c;
      d_o2r  <= o2r;
      d_o2c  <= o2c;
      d_miss <= miss;
    end
  end

  // output stage: read the chosen cells
  function automatic logic [LW-1:0] col_pick(input logic [pdc_pkg::RowW-1:0] row_word,
                                             input logic [IW-1:0] col);
    logic [LW-1:0] res;
    case (col)
      3'd0:    res = row_word[0 * LW +: LW];
      3'd1:    res = row_word[1 * LW +: LW];
      3'd2:    res = row_word[2 * LW +: LW];
      3'd3:    res = row_word[3 * LW +: LW];
      default: res = row_word[4 * LW +: LW];
    endcase
    return res;
  endfunction

  pdc_pkg::out_beat_t res;

  always_comb begin
    res.not_in_square = d_miss;
    res.first_result  = d_miss ? '0 : col_pick(square[d_o1r], d_o1c);
    res.second_result = d_miss ? '0 : col_pick(square[d_o2r], d_o2c);
  end

  always_ff @(posedge clk) begin
    if (en_o && vd) begin
      out_data <= res;
    end
  end

  // a missing letter always gives zero letters
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.not_in_square |->
      out_data.first_result == '0 && out_data.second_result == '0)
    else $error("missing letter with nonzero result");

  // input is only held off by a stalled output
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // nothing comes out of an emptied pipeline
  assert property (@(posedge clk) rst |=> !out_valid && !va && !vd)
    else $error("pipeline not empty after reset");

  // the first encoder's row and the second encoder's column always point inside the square
  assert property (@(posedge clk) disable iff (rst)
    vc && !miss |-> c_loc1.row < IW'(pdc_pkg::Side) && c_loc2.col < IW'(pdc_pkg::Side))
    else $error("located cell outside the square");

endmodule

[tb/sv/playfair_digram_cipher_top_tb.sv]
// Self-checking bench for playfair_digram_cipher_top: digram beats are checked against an
// in-bench Playfair predictor over several key squares and both modes, with random idling.
// Depends on pdc_pkg and the RTL of playfair_digram_cipher_top.
`timescale 1ns / 1ps

module playfair_digram_cipher_top_tb;
  import pdc_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int Latency = 5;
  localparam int CycleLimit = 400000;
  localparam int RandomPerPhase = 88;

  class digram_scoreboard;
    logic            decrypt;
    logic [RowW-1:0] rows [Side];
    out_beat_t       expected_q [$];
    in_beat_t        digram_q [$];
    int              errors;

    function new();
      decrypt = 1'b0;
      rows[0] = SquareRow0Rst;
      rows[1] = SquareRow1Rst;
      rows[2] = SquareRow2Rst;
      rows[3] = SquareRow3Rst;
      rows[4] = SquareRow4Rst;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [RowW-1:0] value);
      if (idx == REG_DECRYPT_MODE) begin
        decrypt = value[0];
      end else begin
        rows[int'(idx) - int'(REG_SQUARE_ROW0)] = value;
      end
    endfunction

    function logic [LetterW-1:0] cell_at(int r, int c);
      return rows[r][LetterW*c +: LetterW];
    endfunction

    // first hit in row-major order wins when a code appears twice
    function bit find_letter(logic [LetterW-1:0] l, output int r, output int c);
      r = 0;
      c = 0;
      for (int i = 0; i < Cells; i++) begin
        if (cell_at(i / Side, i % Side) == l) begin
          r = i / Side;
          c = i % Side;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int shifted(int idx);
      int step;
      step = decrypt ? int'(Side) - 1 : 1;
      return (idx + step) % int'(Side);
    endfunction

    function out_beat_t transform(in_beat_t d);
      logic [LetterW-1:0] a, b;
      int r1, c1, r2, c2, o1r, o1c, o2r, o2c;
      bit f1, f2;
      out_beat_t res;
      a = (d.first_letter == LetterJ) ? LetterI : d.first_letter;
      b = (d.second_letter == LetterJ) ? LetterI : d.second_letter;
      f1 = find_letter(a, r1, c1);
      f2 = find_letter(b, r2, c2);
      res = '0;
      if (!(f1 && f2)) begin
        res.not_in_square = 1'b1;
        return res;
      end
      if (r1 == r2 && c1 == c2) begin
        o1r = shifted(r1);
        o1c = shifted(c1);
        o2r = o1r;
        o2c = o1c;
      end else if (r1 == r2) begin
        o1r = r1;
        o2r = r2;
        o1c = shifted(c1);
        o2c = shifted(c2);
      end else if (c1 == c2) begin
        o1c = c1;
        o2c = c2;
        o1r = shifted(r1);
        o2r = shifted(r2);
      end else begin
        o1r = r1;
        o1c = c2;
        o2r = r2;
        o2c = c1;
      end
      res.first_result = cell_at(o1r, o1c);
      res.second_result = cell_at(o2r, o2c);
      return res;
    endfunction

    function void note_digram(in_beat_t d);
      expected_q.push_back(transform(d));
      digram_q.push_back(d);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      in_beat_t src;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", got, 0);
        return;
      end
      want = expected_q.pop_front();
      src = digram_q.pop_front();
      if (got.first_result !== want.first_result)
        report_mismatch($sformatf("first_result for %0d,%0d", src.first_letter,
                        src.second_letter), got.first_result, want.first_result);
      if (got.second_result !== want.second_result)
        report_mismatch($sformatf("second_result for %0d,%0d", src.first_letter,
                        src.second_letter), got.second_result, want.second_result);
      if (got.not_in_square !== want.not_in_square)
        report_mismatch($sformatf("not_in_square for %0d,%0d", src.first_letter,
                        src.second_letter), got.not_in_square, want.not_in_square);
    endtask
  endclass

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [2:0]      cfg_index;
  logic [RowW-1:0] cfg_data;
  logic            in_valid;
  logic            in_ready;
  in_beat_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_beat_t       out_data;

  int              send_idle_pct;
  int              recv_idle_pct;
  logic            out_hold;
  int unsigned     cycles = 0;
  logic [RowW-1:0] next_square [Side];
  digram_scoreboard sb;

  playfair_digram_cipher_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #HalfPeriod clk = ~clk;

  always @(negedge clk) begin
    out_ready = !out_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[playfair_digram_cipher_top] ERROR");
      $finish;
    end
  end

  // long back-pressure so the pipeline fills and drops in_ready
  task automatic hold_receiver(int n);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (n) @(posedge clk);
    out_hold = 1'b0;
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [RowW-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_square();
    for (int r = 0; r < Side; r++) begin
      cfg_write(cfg_reg_t'(int'(REG_SQUARE_ROW0) + r), next_square[r]);
    end
  endtask

  // shuffled a..z without j; optionally one cell replaced by j
  function automatic void shuffle_square(bit with_j);
    logic [LetterW-1:0] letters [Cells];
    logic [LetterW-1:0] tmp;
    int n, k;
    n = 0;
    for (int l = 0; l < 26; l++) begin
      if (l != int'(LetterJ)) begin
        letters[n] = LetterW'(l);
        n++;
      end
    end
    for (int i = Cells - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = letters[i];
      letters[i] = letters[k];
      letters[k] = tmp;
    end
    if (with_j) letters[$urandom_range(Cells - 1)] = LetterJ;
    for (int i = 0; i < Cells; i++) begin
      next_square[i / Side][LetterW*(i % Side) +: LetterW] = letters[i];
    end
  endfunction

  // mostly letters that sit in the current square, i often given as j
  function automatic logic [LetterW-1:0] pick_letter();
    int r, c;
    logic [LetterW-1:0] l;
    if ($urandom_range(9) < 2) return LetterW'($urandom_range(25));
    r = $urandom_range(Side - 1);
    c = $urandom_range(Side - 1);
    l = sb.rows[r][LetterW*c +: LetterW];
    if (l > 5'd25) return LetterW'($urandom_range(25));
    if (l == LetterI && $urandom_range(1)) return LetterJ;
    return l;
  endfunction

  function automatic in_beat_t digram(int a, int b);
    in_beat_t d;
    d.first_letter = LetterW'(a);
    d.second_letter = LetterW'(b);
    return d;
  endfunction

  // entered and left at a falling edge
  task automatic send_digram(in_beat_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_digram(d);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    in_beat_t d;
    repeat (n) begin
      d.first_letter = pick_letter();
      d.second_letter = ($urandom_range(9) == 0) ? d.first_letter : pick_letter();
      send_digram(d);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (Latency + 1) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    out_hold = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 63;
    sb = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // reset square, encrypt: same cell, rows, columns with wrap, rectangles, j fold
    send_digram(digram(0, 0));
    send_digram(digram(0, 1));
    send_digram(digram(4, 0));
    send_digram(digram(0, 5));
    send_digram(digram(20, 0));
    send_digram(digram(0, 25));
    send_digram(digram(25, 0));
    send_digram(digram(25, 25));
    send_digram(digram(9, 9));
    send_digram(digram(9, 8));
    send_digram(digram(9, 25));
    send_digram(digram(8, 14));
    send_random(RandomPerPhase);
    drain();

    // decrypt, upper bits of the mode write set
    cfg_write(REG_DECRYPT_MODE, '1);
    fork
      hold_receiver(60);
    join_none
    send_digram(digram(0, 0));
    send_digram(digram(0, 1));
    send_digram(digram(0, 5));
    send_digram(digram(0, 25));
    send_digram(digram(9, 9));
    send_digram(digram(24, 20));
    send_random(RandomPerPhase);
    drain();

    cfg_write(REG_DECRYPT_MODE, 25'h1fffffe);
    shuffle_square(1'b0);
    write_square();
    send_random(RandomPerPhase);
    drain();

    send_idle_pct = 63;
    recv_idle_pct = 6;
    cfg_write(REG_DECRYPT_MODE, 25'd1);
    shuffle_square(1'b0);
    write_square();
    send_random(RandomPerPhase);
    drain();

    // last row all code 31, so v..z are missing
    cfg_write(REG_DECRYPT_MODE, '0);
    next_square[0] = SquareRow0Rst;
    next_square[1] = SquareRow1Rst;
    next_square[2] = SquareRow2Rst;
    next_square[3] = SquareRow3Rst;
    next_square[4] = '1;
    write_square();
    send_digram(digram(21, 0));
    send_digram(digram(0, 25));
    send_digram(digram(25, 21));
    send_random(RandomPerPhase);
    drain();

    // every cell holds a
    cfg_write(REG_DECRYPT_MODE, 25'd1);
    for (int r = 0; r < Side; r++) next_square[r] = '0;
    write_square();
    send_random(RandomPerPhase);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(REG_DECRYPT_MODE, RowW'($urandom));
    for (int r = 0; r < Side; r++) next_square[r] = RowW'($urandom);
    write_square();
    fork
      hold_receiver(80);
    join_none
    send_random(RandomPerPhase);
    drain();

    // j sitting in a cell is never matched
    cfg_write(REG_DECRYPT_MODE, 25'd1);
    shuffle_square(1'b1);
    write_square();
    send_random(RandomPerPhase);
    drain();

    if (sb.errors == 0) begin
      $display("[playfair_digram_cipher_top] OK");
    end else begin
      $display("[playfair_digram_cipher_top] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_prio_enc.sv
hw/rtl/playfair_digram_cipher_top.sv
tb/sv/playfair_digram_cipher_top_tb.sv
